@@ hdl/gpe_pkg.sv @@
// Shared types and codes for the GPIO port with edge interrupts.
// No dependencies; imported by gpio_port_edge_interrupt.
package gpe_pkg;

	localparam int WORD_W  = 32;
	localparam int PADS_W  = 16;
	localparam int REQ_W   = 2;
	localparam int INDEX_W = 4;

	// Request kinds; code 3 is unused and does nothing.
	typedef enum logic [REQ_W-1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2
	} req_kind_t;

	// Register map; indexes 12 to 15 are unmapped.
	typedef enum logic [INDEX_W-1:0] {
		REG_MODE    = 4'd0,
		REG_OTYPE   = 4'd1,
		REG_SPEED   = 4'd2,
		REG_PULL    = 4'd3,
		REG_INPUT   = 4'd4,
		REG_OUTPUT  = 4'd5,
		REG_AFL     = 4'd6,
		REG_AFH     = 4'd7,
		REG_MASK    = 4'd8,
		REG_RISE    = 4'd9,
		REG_FALL    = 4'd10,
		REG_PENDING = 4'd11
	} reg_index_t;

	// Two-bit per-pin field codes.
	localparam logic [1:0] MODE_OUTPUT = 2'b01;
	localparam logic [1:0] PULL_UP     = 2'b01;
	localparam logic [1:0] PULL_DOWN   = 2'b10;

endpackage

@@ hdl/gpio_port_edge_interrupt.sv @@
// GPIO port with per-pin edge interrupts: register file, edge detect, pad control.
// Depends on gpe_pkg.
//
// One request (bus read, bus write or pin sample tick) enters per transfer and
// yields exactly one result carrying the read word, the pad control lines and
// irq, all showing the port state after that request. Requests pass through an
// input register (_s1), are applied to the register file by short combinational
// logic, and land in a result register; a new request is taken every cycle
// while results are taken, so the port sustains one request per clock. in_ready
// drops only when both the input register and the result register are full
// and the result is stalled.
// Writes to the pending register clear the bits written as one; writes to the
// input register and to unmapped indexes are dropped, and unmapped indexes read
// as zero. Bits of pins at or above PIN_COUNT are dropped on write and read as
// zero. On a tick the pads are latched into the input register and any pin with
// a selected edge and an unmasked interrupt becomes pending; the input register
// resets to zero, so a pad high on the first tick counts as a rising edge.
module gpio_port_edge_interrupt #(
	parameter int PIN_COUNT = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gpe_pkg::REQ_W-1:0]      req_type,
	input  logic [gpe_pkg::INDEX_W-1:0]    reg_index,
	input  logic [gpe_pkg::WORD_W-1:0]     write_data,
	input  logic [gpe_pkg::PADS_W-1:0]     pin_levels,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gpe_pkg::WORD_W-1:0]     read_data,
	output logic [gpe_pkg::PADS_W-1:0]     pin_drive,
	output logic [gpe_pkg::PADS_W-1:0]     pin_drive_enable,
	output logic [gpe_pkg::PADS_W-1:0]     pull_up_enable,
	output logic [gpe_pkg::PADS_W-1:0]     pull_down_enable,
	output logic                           irq
);
	import gpe_pkg::*;

	localparam int F2_W     = 2 * PIN_COUNT;
	localparam int AFL_BITS = (PIN_COUNT >= 8) ? 32 : (4 * PIN_COUNT);
	localparam int AFH_BITS = (PIN_COUNT > 8) ? (4 * (PIN_COUNT - 8)) : 0;
	localparam logic [63:0] AFL_MASK64 = (64'd1 << AFL_BITS) - 64'd1;
	localparam logic [63:0] AFH_MASK64 = (64'd1 << AFH_BITS) - 64'd1;
	localparam logic [WORD_W-1:0] AFL_MASK = AFL_MASK64[WORD_W-1:0];
	localparam logic [WORD_W-1:0] AFH_MASK = AFH_MASK64[WORD_W-1:0];

	// Input stage
	logic                  valid_s1;
	req_kind_t             req_s1;
	reg_index_t            index_s1;
	logic [WORD_W-1:0]     wdata_s1;
	logic [PIN_COUNT-1:0]  pads_s1;
	logic                  advance;

	// Register file
	logic [F2_W-1:0]       mode_q, speed_q, pull_q;
	logic [PIN_COUNT-1:0]  otype_q, input_q, output_q, mask_q, rise_q, fall_q, pending_q;
	logic [WORD_W-1:0]     afl_q, afh_q;

	logic [F2_W-1:0]       mode_d, speed_d, pull_d;
	logic [PIN_COUNT-1:0]  otype_d, input_d, output_d, mask_d, rise_d, fall_d, pending_d;
	logic [WORD_W-1:0]     afl_d, afh_d;
	logic [WORD_W-1:0]     rdata_d;
	logic [PIN_COUNT-1:0]  hits;

	logic [PIN_COUNT-1:0]  outmode_d, pu_d, pd_d, enable_d;

	// Advance the input stage whenever the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1   <= req_kind_t'(req_type);
			index_s1 <= reg_index_t'(reg_index);
			wdata_s1 <= write_data;
			pads_s1  <= pin_levels[PIN_COUNT-1:0];
		end
	end

	// Edge detect against the last sampled pad levels; masked lines never set pending.
	assign hits = ((pads_s1 & ~input_q & rise_q) | (input_q & ~pads_s1 & fall_q)) & mask_q;

	// Apply the request to the register file and form the read word.
	always_comb begin
		mode_d    = mode_q;
		otype_d   = otype_q;
		speed_d   = speed_q;
		pull_d    = pull_q;
		input_d   = input_q;
		output_d  = output_q;
		afl_d     = afl_q;
		afh_d     = afh_q;
		mask_d    = mask_q;
		rise_d    = rise_q;
		fall_d    = fall_q;
		pending_d = pending_q;
		rdata_d   = '0;
		unique case (req_s1)
			REQ_READ: begin
				unique case (index_s1)
					REG_MODE:    rdata_d = WORD_W'(mode_q);
					REG_OTYPE:   rdata_d = WORD_W'(otype_q);
					REG_SPEED:   rdata_d = WORD_W'(speed_q);
					REG_PULL:    rdata_d = WORD_W'(pull_q);
					REG_INPUT:   rdata_d = WORD_W'(input_q);
					REG_OUTPUT:  rdata_d = WORD_W'(output_q);
					REG_AFL:     rdata_d = afl_q;
					REG_AFH:     rdata_d = afh_q;
					REG_MASK:    rdata_d = WORD_W'(mask_q);
					REG_RISE:    rdata_d = WORD_W'(rise_q);
					REG_FALL:    rdata_d = WORD_W'(fall_q);
					REG_PENDING: rdata_d = WORD_W'(pending_q);
					default:     rdata_d = '0;
				endcase
			end
			REQ_WRITE: begin
				unique case (index_s1)
					REG_MODE:    mode_d    = wdata_s1[F2_W-1:0];
					REG_OTYPE:   otype_d   = wdata_s1[PIN_COUNT-1:0];
					REG_SPEED:   speed_d   = wdata_s1[F2_W-1:0];
					REG_PULL:    pull_d    = wdata_s1[F2_W-1:0];
					REG_OUTPUT:  output_d  = wdata_s1[PIN_COUNT-1:0];
					REG_AFL:     afl_d     = wdata_s1 & AFL_MASK;
					REG_AFH:     afh_d     = wdata_s1 & AFH_MASK;
					REG_MASK:    mask_d    = wdata_s1[PIN_COUNT-1:0];
					REG_RISE:    rise_d    = wdata_s1[PIN_COUNT-1:0];
					REG_FALL:    fall_d    = wdata_s1[PIN_COUNT-1:0];
					// write one to clear
					REG_PENDING: pending_d = pending_q & ~wdata_s1[PIN_COUNT-1:0];
					default:     ;
				endcase
			end
			REQ_TICK: begin
				pending_d = pending_q | hits;
				input_d   = pads_s1;
			end
			default: ;
		endcase
	end

	// Per-pin decode of the 2-bit fields after the update.
	always_comb begin
		for (int p = 0; p < PIN_COUNT; p++) begin
			outmode_d[p] = (mode_d[2*p +: 2] == MODE_OUTPUT);
			pu_d[p]      = (pull_d[2*p +: 2] == PULL_UP);
			pd_d[p]      = (pull_d[2*p +: 2] == PULL_DOWN);
		end
	end

	// Open-drain pins drive only lows.
	assign enable_d = outmode_d & (~otype_d | ~output_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '0;
			otype_q   <= '0;
			speed_q   <= '0;
			pull_q    <= '0;
			input_q   <= '0;
			output_q  <= '0;
			afl_q     <= '0;
			afh_q     <= '0;
			mask_q    <= '0;
			rise_q    <= '0;
			fall_q    <= '0;
			pending_q <= '0;
		end else if (advance) begin
			mode_q    <= mode_d;
			otype_q   <= otype_d;
			speed_q   <= speed_d;
			pull_q    <= pull_d;
			input_q   <= input_d;
			output_q  <= output_d;
			afl_q     <= afl_d;
			afh_q     <= afh_d;
			mask_q    <= mask_d;
			rise_q    <= rise_d;
			fall_q    <= fall_d;
			pending_q <= pending_d;
		end
	end

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data        <= rdata_d;
			pin_drive        <= PADS_W'(output_d);
			pin_drive_enable <= PADS_W'(enable_d);
			pull_up_enable   <= PADS_W'(pu_d);
			pull_down_enable <= PADS_W'(pd_d);
			irq              <= |(pending_d & mask_d);
		end
	end

	// irq shown with a result matches the register file it was computed from.
	a_irq_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (irq == |(pending_q & mask_q)))
		else $error("irq disagrees with pending and mask registers");

	// Only a sample tick can set new pending bits.
	a_pending_set_by_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1 != REQ_TICK) |=> ((pending_q & ~$past(pending_q)) == '0))
		else $error("pending bit set by a non-tick request");

	// Drop in_ready only when both stages are full and the result stalls.
	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !out_valid || out_ready) |-> in_ready)
		else $error("input stalled while there is room");

	// The register file changes only when a request is applied.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(pending_q) && $stable(mode_q) && $stable(output_q)))
		else $error("register file changed without a request");

endmodule
